[src/mfms_pkg.sv]
`default_nettype none

package mfms_pkg;

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 32;
  localparam int WIN_LEN     = 10;
  localparam int HIST_LEN    = WIN_LEN - 1;
  localparam int NUM_MARKERS = 6;

  localparam logic [CNT_W-1:0] MAX_BYTES_RST = 32'd1048576;
  localparam logic [CNT_W-1:0] CNT_SAT       = '1;

  // markers right-aligned in the window, oldest char in the top byte
  localparam logic [WIN_LEN*BYTE_W-1:0] MARKER_TXT [NUM_MARKERS] = '{
    {8'h00, "<!doctype"},
    {16'h0000, "<!entity"},
    {8'h00, "<!element"},
    {8'h00, "<!attlist"},
    "xi:include",
    {16'h0000, "xinclude"}
  };

  localparam int MARKER_LEN [NUM_MARKERS] = '{9, 8, 9, 9, 10, 8};

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_TOO_LARGE = 2'd1,
    VERDICT_FORBIDDEN = 2'd2
  } verdict_e;

  typedef logic [NUM_MARKERS-1:0][BYTE_W-1:0] exp_chars_t;

  typedef struct packed {
    logic beat;
    logic last;
    logic hit;
  } tally_in_t;

  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if ((c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/mfms_cell.sv]
`default_nettype none

module mfms_cell (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    shift_i,
  input  wire logic                                    clear_i,
  input  wire logic [mfms_pkg::BYTE_W-1:0]             byte_i,
  input  wire mfms_pkg::exp_chars_t                    exp_i,
  input  wire logic [mfms_pkg::NUM_MARKERS-1:0]        care_i,
  output logic      [mfms_pkg::BYTE_W-1:0]             byte_o,
  output logic      [mfms_pkg::NUM_MARKERS-1:0]        hit_o
);

  logic [mfms_pkg::BYTE_W-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = clear_i ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  always_comb begin
    for (int m = 0; m < mfms_pkg::NUM_MARKERS; m++) begin
      hit_o[m] = !care_i[m] || (byte_q == exp_i[m]);
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

[src/mfms_tally.sv]
`default_nettype none

module mfms_tally (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mfms_pkg::tally_in_t           st_i,
  input  wire logic [mfms_pkg::CNT_W-1:0]    max_bytes_i,
  output mfms_pkg::verdict_e                 verdict_o
);

  logic [mfms_pkg::CNT_W-1:0] count_q, count_d, count_inc;
  logic                       seen_q, seen_d, seen_now;

  assign count_inc = (count_q == mfms_pkg::CNT_SAT) ? count_q
                                                    : count_q + (mfms_pkg::CNT_W)'(1);
  assign seen_now  = seen_q || st_i.hit;

  always_comb begin
    count_d = count_q;
    seen_d  = seen_q;
    if (st_i.beat) begin
      count_d = st_i.last ? '0 : count_inc;
      seen_d  = st_i.last ? 1'b0 : seen_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    if (count_inc > max_bytes_i) begin
      verdict_o = mfms_pkg::VERDICT_TOO_LARGE;
    end else if (seen_now) begin
      verdict_o = mfms_pkg::VERDICT_FORBIDDEN;
    end else begin
      verdict_o = mfms_pkg::VERDICT_ACCEPT;
    end
  end

endmodule

`default_nettype wire

[src/markup_forbidden_marker_scan.sv]
// channel | direction | handshake              | payload
// in      | in        | in_valid_i/in_ready_o   | data_byte_i, last_byte_i
// out     | out       | out_valid_o/out_ready_i | verdict_o
// cfg     | in        | cfg_valid_i/cfg_ready_o | max_bytes_i
//
// One byte beat per cycle while in_ready_o is high; the verdict is valid the cycle after the final byte.
// The nine-cell history chain and the count compare both settle in the final byte's cycle.
// in_ready_o drops only while a verdict is held and out_ready_i is low.
// Reset clears history, count, flag and output valid; max_bytes returns to 1048576.
// cfg_ready_o is always high.
`default_nettype none

module markup_forbidden_marker_scan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mfms_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                          last_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [1:0]                    verdict_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mfms_pkg::CNT_W-1:0]    max_bytes_i
);

  localparam int BW = mfms_pkg::BYTE_W;
  localparam int NM = mfms_pkg::NUM_MARKERS;
  localparam int WL = mfms_pkg::WIN_LEN;
  localparam int HL = mfms_pkg::HIST_LEN;

  logic                         beat;
  logic [BW-1:0]                cur_byte;
  logic [HL:0][BW-1:0]          chain;
  logic [WL-1:0][NM-1:0]        pos_hit;
  logic                         win_hit;
  mfms_pkg::tally_in_t          tally_in;
  mfms_pkg::verdict_e           verdict_d, verdict_q;
  logic                         out_valid_q, out_valid_d;
  logic [mfms_pkg::CNT_W-1:0]   max_bytes_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign beat       = in_valid_i && in_ready_o;
  assign cur_byte   = mfms_pkg::fold_lower(data_byte_i);
  assign chain[HL]  = cur_byte;

  for (genvar g = 0; g < HL; g++) begin : g_cell
    mfms_pkg::exp_chars_t exp_c;
    logic [NM-1:0]        care_c;
    for (genvar m = 0; m < NM; m++) begin : g_exp
      assign exp_c[m]  = mfms_pkg::MARKER_TXT[m][(WL-1-g)*BW +: BW];
      assign care_c[m] = (g >= WL - mfms_pkg::MARKER_LEN[m]);
    end
    mfms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (beat),
      .clear_i (last_byte_i),
      .byte_i  (chain[g+1]),
      .exp_i   (exp_c),
      .care_i  (care_c),
      .byte_o  (chain[g]),
      .hit_o   (pos_hit[g])
    );
  end

  // current byte sits at the last window position; every marker cares about it
  for (genvar m = 0; m < NM; m++) begin : g_cur
    assign pos_hit[WL-1][m] = (cur_byte == mfms_pkg::MARKER_TXT[m][BW-1:0]);
  end

  always_comb begin
    logic [NM-1:0] mk;
    mk = '1;
    for (int p = 0; p < WL; p++) begin
      mk = mk & pos_hit[p];
    end
    win_hit = |mk;
  end

  assign tally_in.beat = beat;
  assign tally_in.last = last_byte_i;
  assign tally_in.hit  = win_hit;

  mfms_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_i        (tally_in),
    .max_bytes_i (max_bytes_q),
    .verdict_o   (verdict_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (beat && last_byte_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      max_bytes_q <= mfms_pkg::MAX_BYTES_RST;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_bytes_q <= max_bytes_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && last_byte_i) begin
      verdict_q <= verdict_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = 2'(verdict_q);

endmodule

`default_nettype wire

[src/mfms_checker.sv]
`default_nettype none

module mfms_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       last_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] verdict_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o))
    else $error("verdict beat dropped or changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o != 2'd3)
    else $error("undefined verdict code");

  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> out_valid_o)
    else $error("final byte gave no verdict");

  a_mid_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_byte_i && (!out_valid_o || out_ready_i)
      |=> !out_valid_o)
    else $error("verdict without final byte");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while verdict stalled");

endmodule

bind markup_forbidden_marker_scan mfms_checker u_mfms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_byte_i (last_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .verdict_o   (verdict_o)
);

`default_nettype wire
